/* rtl/lpi_pkg.sv */
package lpi_pkg;

  // coordinate and arithmetic widths
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ACC_W       = DATA_W + 1;
  localparam int unsigned COUNT_W     = 7;

  // one quotient bit per divide cycle over the 32-bit magnitude
  localparam int unsigned DIV_STEPS   = DATA_W;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

  // stream payload layout
  localparam int unsigned IN_TDATA_W  = 200;
  localparam int unsigned OUT_TDATA_W = 3 * DATA_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIVIDE,
    ST_SIGN,
    ST_EMIT
  } lpi_state_e;

  // lockstep commands from the sequencer to every lane
  typedef struct packed {
    logic load;     // latch start point and difference
    logic prep;     // take magnitude of the difference
    logic div;      // one restoring divide step
    logic sign;     // apply sign to the quotient
    logic advance;  // add step into the accumulator
  } lpi_ctrl_t;

endpackage

/* rtl/lpi_lane.sv */
module lpi_lane #(
  parameter int unsigned DIV_W = 6
) (
  input  logic                             clk_i,
  input  lpi_pkg::lpi_ctrl_t               ctrl_i,
  input  logic [lpi_pkg::DATA_W-1:0]       from_i,
  input  logic [lpi_pkg::DATA_W-1:0]       to_i,
  input  logic [DIV_W-1:0]                 divisor_i,
  output logic [lpi_pkg::DATA_W-1:0]       point_o
);
  import lpi_pkg::*;

  logic [ACC_W-1:0]  work_q, work_d;
  logic [ACC_W-1:0]  accum_q, accum_d;
  logic [ACC_W-1:0]  step_q, step_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic              neg_q, neg_d;
  logic [DIV_W:0]    rem_sh;
  logic              q_bit;

  // restoring divide: shift one dividend bit into the remainder
  assign rem_sh = {rem_q, work_q[DATA_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, divisor_i});

  always_comb begin
    work_d  = work_q;
    accum_d = accum_q;
    step_d  = step_q;
    rem_d   = rem_q;
    neg_d   = neg_q;
    if (ctrl_i.load) begin
      work_d  = {to_i[DATA_W-1], to_i} - {from_i[DATA_W-1], from_i};
      accum_d = {from_i[DATA_W-1], from_i};
      step_d  = '0;
      rem_d   = '0;
    end else if (ctrl_i.prep) begin
      neg_d  = work_q[ACC_W-1];
      work_d = work_q[ACC_W-1] ? (~work_q + ACC_W'(1)) : work_q;
    end else if (ctrl_i.div) begin
      work_d = {1'b0, work_q[DATA_W-2:0], q_bit};
      rem_d  = q_bit ? DIV_W'(rem_sh - {1'b0, divisor_i}) : rem_sh[DIV_W-1:0];
    end else if (ctrl_i.sign) begin
      step_d = neg_q ? (~{1'b0, work_q[DATA_W-1:0]} + ACC_W'(1))
                     : {1'b0, work_q[DATA_W-1:0]};
    end else if (ctrl_i.advance) begin
      accum_d = accum_q + step_q;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q  <= work_d;
    accum_q <= accum_d;
    step_q  <= step_d;
    rem_q   <= rem_d;
    neg_q   <= neg_d;
  end

  assign point_o = accum_q[DATA_W-1:0];

endmodule

/* rtl/lpi_merge.sv */
module lpi_merge (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  logic [lpi_pkg::DATA_W-1:0]          x_i,
  input  logic [lpi_pkg::DATA_W-1:0]          y_i,
  input  logic [lpi_pkg::DATA_W-1:0]          z_i,
  input  logic                                last_i,
  output logic                                ready_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [lpi_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,  // x_out, y_out, z_out
  output logic                                m_axis_tlast_o   // last_point
);
  import lpi_pkg::*;

  logic                   valid_q, valid_d;
  logic [OUT_TDATA_W-1:0] data_q;
  logic                   last_q;

  // output register frees when empty or being taken
  assign ready_o = !valid_q || m_axis_tready_i;
  assign valid_d = push_i || (valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= {z_i, y_i, x_i};
      last_q <= last_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tlast_o  = last_q;

endmodule

/* rtl/linear_point_interpolator_top.sv */
// Linear point interpolator: each request carries a start and an end point
// (x, y, depth, signed Q15.16) and a point count n, and the block emits n
// points on the master stream, the start point first and then running sums
// of the per-component step (end - start) / (n - 1), truncated toward zero,
// with tlast on the final point. A count of zero is taken as one, a count
// above MAX_COUNT is clipped to MAX_COUNT, and a count of one emits only the
// start point. Three lanes, one per component, run in lockstep; each has a
// restoring divider that produces one quotient bit per cycle over the 32-bit
// difference magnitude. A request is accepted, its magnitude formed, the
// quotient divided out and the sign applied before the points are emitted
// (a single point goes straight from acceptance to emission), and emission
// waits while the output stream stalls. One request is worked on at a time:
// the slave side is ready only while the block is idle.
module linear_point_interpolator_top #(
  parameter int unsigned MAX_COUNT = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // x_from, y_from, z_from, x_to, y_to, z_to, point_count, one pad bit
  input  logic [lpi_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // x_out, y_out, z_out
  output logic [lpi_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // last_point
  output logic                               m_axis_tlast_o
);
  import lpi_pkg::*;

  localparam int unsigned DIV_W = (MAX_COUNT > 2) ? $clog2(MAX_COUNT) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_COUNT + 1);

  lpi_state_e           state_q, state_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
  logic [CNT_W-1:0]     left_q, left_d;
  logic [DIV_W-1:0]     divisor_q, divisor_d;
  lpi_ctrl_t            ctrl;
  logic                 accept;
  logic                 push;
  logic                 merge_ready;
  logic [COUNT_W-1:0]   count_in;
  logic [COUNT_W-1:0]   count_sat;
  logic                 is_last;
  logic [DATA_W-1:0]    x_pt, y_pt, z_pt;

  // request fields by component
  logic [DATA_W-1:0] from_pt [3];
  logic [DATA_W-1:0] to_pt   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      from_pt[i] = s_axis_tdata_i[i*DATA_W +: DATA_W];
      to_pt[i]   = s_axis_tdata_i[(i+3)*DATA_W +: DATA_W];
    end
  end

  assign count_in = s_axis_tdata_i[6*DATA_W +: COUNT_W];

  // zero counts as one, large counts clip to the maximum
  always_comb begin
    if (count_in == '0) begin
      count_sat = COUNT_W'(1);
    end else if (count_in > COUNT_W'(MAX_COUNT)) begin
      count_sat = COUNT_W'(MAX_COUNT);
    end else begin
      count_sat = count_in;
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign is_last         = (left_q == CNT_W'(1));
  assign push            = (state_q == ST_EMIT) && merge_ready;

  // sequencer: next state and lane commands
  always_comb begin
    state_d     = state_q;
    div_cnt_d   = div_cnt_q;
    left_d      = left_q;
    divisor_d   = divisor_q;
    ctrl        = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ctrl.load = 1'b1;
          left_d    = CNT_W'(count_sat);
          divisor_d = DIV_W'(count_sat - COUNT_W'(1));
          // a single point needs no step
          state_d   = (count_sat == COUNT_W'(1)) ? ST_EMIT : ST_PREP;
        end
      end
      ST_PREP: begin
        ctrl.prep = 1'b1;
        state_d   = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        ctrl.div  = 1'b1;
        div_cnt_d = div_cnt_q + DIV_CNT_W'(1);
        if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          div_cnt_d = '0;
          state_d   = ST_SIGN;
        end
      end
      ST_SIGN: begin
        ctrl.sign = 1'b1;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (push) begin
          left_d       = left_q - CNT_W'(1);
          ctrl.advance = !is_last;
          if (is_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      div_cnt_q <= '0;
      left_q    <= '0;
      divisor_q <= '0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
      left_q    <= left_d;
      divisor_q <= divisor_d;
    end
  end

  // one lane per component
  lpi_lane #(.DIV_W(DIV_W)) u_lane_x (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .from_i    (from_pt[0]),
    .to_i      (to_pt[0]),
    .divisor_i (divisor_q),
    .point_o   (x_pt)
  );

  lpi_lane #(.DIV_W(DIV_W)) u_lane_y (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .from_i    (from_pt[1]),
    .to_i      (to_pt[1]),
    .divisor_i (divisor_q),
    .point_o   (y_pt)
  );

  lpi_lane #(.DIV_W(DIV_W)) u_lane_z (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .from_i    (from_pt[2]),
    .to_i      (to_pt[2]),
    .divisor_i (divisor_q),
    .point_o   (z_pt)
  );

  // gather lane points into the output register
  lpi_merge u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .x_i             (x_pt),
    .y_i             (y_pt),
    .z_i             (z_pt),
    .last_i          (is_last),
    .ready_o         (merge_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

`ifndef SYNTH
  // a taken request closes the slave side on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready_o)
    else $error("slave side still ready after a request was taken");

  // emission never runs with no points left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (left_q != '0))
    else $error("emitting with an empty point count");

  // divide step counter rests at zero outside the divide phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_DIVIDE) |-> (div_cnt_q == '0))
    else $error("divide counter not at rest");
`endif

endmodule

/* tb/linear_point_interpolator_top_tb.sv */
module linear_point_interpolator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpi_pkg::*;

  localparam int unsigned MAX_COUNT    = 64;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned RANDOM_ITEMS = 28;   // per phase, four phases
  localparam int unsigned DRAIN_CYCLES = 48;
  localparam int unsigned REPORT_LIMIT = 10;

  // one segment request: start point, end point and point count
  typedef struct {
    int       from_c[3];
    int       to_c[3];
    bit [6:0] count;
  } segment_t;

  // one emitted point
  typedef struct {
    int coord[3];
    bit last;
  } point_t;

  // directed row; a typed row carries its single expected point
  typedef struct {
    int       xf, yf, zf, xt, yt, zt;
    bit [6:0] count;
    bit       typed;
    int       ex, ey, ez;
  } bench_row_t;

  localparam int MIN_C = int'(32'h8000_0000);
  localparam int MAX_C = int'(32'h7fff_ffff);
  localparam int ONE_Q = int'(32'h0001_0000);

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tlast_o;

  point_t      expected_points[$];
  int unsigned mismatches;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  bit          hold_off_req;

  bench_row_t directed_rows [18] = '{
    '{0, 0, 0, 0, 0, 0, 7'd0, 1'b1, 0, 0, 0},
    '{1, 2, 3, MAX_C, MIN_C, MAX_C, 7'd1, 1'b1, 1, 2, 3},
    '{MIN_C, MAX_C, MIN_C, MAX_C, MIN_C, MAX_C, 7'd0, 1'b1, MIN_C, MAX_C, MIN_C},
    '{MAX_C, MAX_C, MAX_C, MIN_C, MIN_C, MIN_C, 7'd1, 1'b1, MAX_C, MAX_C, MAX_C},
    '{MIN_C, MIN_C, MIN_C, MAX_C, MAX_C, MAX_C, 7'd2, 1'b0, 0, 0, 0},
    '{MAX_C, MAX_C, MAX_C, MIN_C, MIN_C, MIN_C, 7'd2, 1'b0, 0, 0, 0},
    '{MIN_C, MAX_C, MIN_C, MAX_C, MIN_C, MAX_C, 7'd64, 1'b0, 0, 0, 0},
    '{MAX_C, MIN_C, MAX_C, MIN_C, MAX_C, MIN_C, 7'd64, 1'b0, 0, 0, 0},
    '{MIN_C, 0, -7, MAX_C, 12345, 7, 7'd65, 1'b0, 0, 0, 0},
    '{-3 * ONE_Q, 5, MAX_C, 9 * ONE_Q, -5, MIN_C, 7'd127, 1'b0, 0, 0, 0},
    '{0, 0, 0, -5, 5, -1, 7'd3, 1'b0, 0, 0, 0},
    '{ONE_Q, -ONE_Q, 77, ONE_Q, -ONE_Q, 77, 7'd4, 1'b0, 0, 0, 0},
    '{ONE_Q, 2 * ONE_Q, 0, 10 * ONE_Q, -2 * ONE_Q, ONE_Q, 7'd10, 1'b0, 0, 0, 0},
    '{-(ONE_Q + ONE_Q / 2), 0, 3, 2 * ONE_Q + ONE_Q / 4, 1, -3, 7'd7, 1'b0, 0, 0, 0},
    '{MIN_C, MAX_C, 0, 0, 0, MAX_C, 7'd33, 1'b0, 0, 0, 0},
    '{-1, 1, -100, 1000, -1000, 100, 7'd32, 1'b0, 0, 0, 0},
    '{MAX_C, -ONE_Q, 31, MIN_C, ONE_Q, -31, 7'd16, 1'b0, 0, 0, 0},
    '{-9, 8, -7, 60, 50, 40, 7'd1, 1'b1, -9, 8, -7}
  };

  linear_point_interpolator_top #(
    .MAX_COUNT (MAX_COUNT)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // step per component is (end - start) / (n - 1), truncated toward zero,
  // and the points are running sums of it from the start point
  function automatic void interpolate_points(segment_t seg);
    int unsigned n;
    longint      step_c[3];
    longint      acc_c[3];
    point_t      pt;
    n = seg.count;
    if (n == 0) begin
      n = 1;
    end else if (n > MAX_COUNT) begin
      n = MAX_COUNT;
    end
    for (int c = 0; c < 3; c++) begin
      step_c[c] = 0;
      if (n > 1) begin
        step_c[c] = (longint'(seg.to_c[c]) - longint'(seg.from_c[c])) / longint'(n - 1);
      end
      acc_c[c] = seg.from_c[c];
    end
    for (int unsigned k = 0; k < n; k++) begin
      for (int c = 0; c < 3; c++) begin
        pt.coord[c] = int'(acc_c[c]);
        acc_c[c] += step_c[c];
      end
      pt.last = (k == n - 1);
      expected_points = {expected_points, pt};
    end
  endfunction

  function automatic int random_coord();
    case ($urandom_range(0, 9))
      0:       return MIN_C;
      1:       return MAX_C;
      2, 3, 4: return int'($urandom);
      default: return int'($urandom_range(0, 32'h0020_0000)) - int'(32'h0010_0000);
    endcase
  endfunction

  // mostly short runs, a few long ones, and some zero or oversized counts
  function automatic segment_t random_segment();
    segment_t seg;
    int unsigned pick;
    for (int c = 0; c < 3; c++) begin
      seg.from_c[c] = random_coord();
      seg.to_c[c]   = ($urandom_range(0, 9) == 0) ? seg.from_c[c] : random_coord();
    end
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      seg.count = 7'($urandom_range(1, 8));
    end else if (pick < 80) begin
      seg.count = 7'($urandom_range(9, 32));
    end else if (pick < 88) begin
      seg.count = 7'($urandom_range(33, 64));
    end else if (pick < 93) begin
      seg.count = 7'd0;
    end else begin
      seg.count = 7'($urandom_range(65, 127));
    end
    return seg;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance;
  // tvalid is left high so the next request can follow without a gap
  task automatic offer_segment(segment_t seg, bit typed, point_t typed_pt);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    // x_from, y_from, z_from, x_to, y_to, z_to, point_count, one pad bit
    s_axis_tdata_i  = {1'b0, seg.count, seg.to_c[2], seg.to_c[1], seg.to_c[0],
                       seg.from_c[2], seg.from_c[1], seg.from_c[0]};
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (typed) begin
      expected_points = {expected_points, typed_pt};
    end else begin
      interpolate_points(seg);
    end
    @(negedge clk_i);
  endtask

  task automatic note_mismatch(string field, int exp_v, int got_v);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("mismatch on %s: expected %h, got %h", field, exp_v, got_v);
    end
  endtask

  // request side: reset, directed table, then four phases of random requests
  initial begin
    segment_t seg;
    point_t   typed_pt;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_off_req       = 1'b0;
    mismatches         = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      seg.from_c = '{directed_rows[i].xf, directed_rows[i].yf, directed_rows[i].zf};
      seg.to_c   = '{directed_rows[i].xt, directed_rows[i].yt, directed_rows[i].zt};
      seg.count  = directed_rows[i].count;
      typed_pt.coord = '{directed_rows[i].ex, directed_rows[i].ey, directed_rows[i].ez};
      typed_pt.last  = 1'b1;
      offer_segment(seg, directed_rows[i].typed, typed_pt);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 81; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 81; end
        default: begin sender_idle_pct = 30; receiver_stall_pct = 30; end
      endcase
      for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
        // long output hold-off while requests keep coming
        if (phase == 0 && i == 10) hold_off_req = 1'b1;
        offer_segment(random_segment(), 1'b0, typed_pt);
      end
      // pause until the block has drained before the next phase
      s_axis_tvalid_i = 1'b0;
      while (expected_points.size() != 0) @(negedge clk_i);
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // result side back-pressure, including one long hold-off
  initial begin
    int unsigned hold_left;
    hold_left       = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && hold_off_req) begin
        hold_left    = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i = 1'b0;
      end else begin
        m_axis_tready_i = ($urandom_range(0, 99) >= receiver_stall_pct);
      end
    end
  end

  // compare each accepted point with the oldest expectation
  initial begin
    point_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_points.size() == 0) begin
          note_mismatch("unexpected point", 0, int'(m_axis_tdata_o[31:0]));
        end else begin
          want = expected_points.pop_front();
          if (int'(m_axis_tdata_o[31:0]) != want.coord[0])
            note_mismatch("x_out", want.coord[0], int'(m_axis_tdata_o[31:0]));
          if (int'(m_axis_tdata_o[63:32]) != want.coord[1])
            note_mismatch("y_out", want.coord[1], int'(m_axis_tdata_o[63:32]));
          if (int'(m_axis_tdata_o[95:64]) != want.coord[2])
            note_mismatch("z_out", want.coord[2], int'(m_axis_tdata_o[95:64]));
          if (m_axis_tlast_o !== want.last)
            note_mismatch("last_point", int'(want.last), int'(m_axis_tlast_o));
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
